[rtl/ata_pkg.sv]
// Shared constants, tables and types for the accelerometer tilt angle block.
package ata_pkg;

  // Default configuration of the converter and the fixed-point format.
  localparam int ADC_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF = 12;

  // Port widths fixed by the interface.
  localparam int RAW_W = 10;
  localparam int G_OUT_W = 16;
  localparam int ANG_OUT_W = 17;
  localparam int DELTA_OUT_W = 18;

  // CORDIC setup: step count, pre-scale of the operands and angle resolution.
  localparam int CORDIC_STEPS = 20;
  localparam int PRE_SHIFT = 16;
  localparam int ANG_BITS = 20;
  localparam int ANG_W = 23;

  // Status that one lane reports back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } lane_st_t;

  // Arctangent of 2^-i in units of 2^-20 rad.
  function automatic logic signed [ANG_W-1:0] atan_val(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0: v = 23'sd823550;
      5'd1: v = 23'sd486170;
      5'd2: v = 23'sd256879;
      5'd3: v = 23'sd130396;
      5'd4: v = 23'sd65451;
      5'd5: v = 23'sd32757;
      5'd6: v = 23'sd16383;
      5'd7: v = 23'sd8192;
      5'd8: v = 23'sd4096;
      5'd9: v = 23'sd2048;
      5'd10: v = 23'sd1024;
      5'd11: v = 23'sd512;
      5'd12: v = 23'sd256;
      5'd13: v = 23'sd128;
      5'd14: v = 23'sd64;
      5'd15: v = 23'sd32;
      5'd16: v = 23'sd16;
      5'd17: v = 23'sd8;
      5'd18: v = 23'sd4;
      5'd19: v = 23'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/ata_gconv.sv]
// One axis lane: ADC code to acceleration in g by reciprocal multiplication.
module ata_gconv #(
  parameter int ADC_BITS = ata_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = ata_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ata_pkg::RAW_W-1:0]     code,
  output logic signed [FRAC_BITS+3:0]   g,
  output ata_pkg::lane_st_t             st
);

  localparam int CW = (ADC_BITS > ata_pkg::RAW_W) ? ADC_BITS : ata_pkg::RAW_W;
  localparam int QW = FRAC_BITS + 4;
  localparam int NW = CW + 4 + FRAC_BITS;
  // The reciprocal is exact for every dividend below 2^NW, since its excess
  // over 2^KSH/FS never lifts a quotient past the next integer.
  localparam int KSH = NW + CW;
  localparam int RCW = NW + CW - ADC_BITS + 2;
  localparam logic [CW-1:0] FS = CW'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [NW-1:0] HALF_FS = NW'(FS >> 1);
  localparam logic [RCW-1:0] RECIP = RCW'(((64'd1 << KSH) / 64'(FS)) + 64'd1);
  localparam logic signed [QW:0] OFFSET = (QW + 1)'(5 << FRAC_BITS);

  logic [NW-1:0]       num_r, num_nxt;
  logic [QW-1:0]       q_r, q_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CW-1:0]       code_ext;
  logic [CW-1:0]       code_sat;
  logic [NW-1:0]       num;
  logic [NW+RCW-1:0]   prod;
  logic signed [QW:0]  g_full;

  // Saturate the code at full scale and form the rounded dividend.
  always_comb begin
    code_ext = CW'(code);
    code_sat = (code_ext > FS) ? FS : code_ext;
    num = ((NW'(code_sat) * NW'(10)) << FRAC_BITS) + HALF_FS;
    prod = (NW + RCW)'(num_r) * (NW + RCW)'(RECIP);
  end

  // Dividend is registered on start, the quotient in the following cycle.
  always_comb begin
    num_nxt = num_r;
    q_nxt = q_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = num;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = prod[KSH +: QW];
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    q_r <= q_nxt;
  end

  // Remove the zero-g offset.
  assign g_full = $signed({1'b0, q_r}) - OFFSET;
  assign g = g_full[QW-1:0];
  assign st.busy = busy_r;
  assign st.done = done_r;

endmodule

[rtl/ata_tilt.sv]
// One angle lane: 10*atan2(a, sqrt(b^2+c^2)) by an iterative root and CORDIC.
module ata_tilt #(
  parameter int FRAC_BITS = ata_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [FRAC_BITS+3:0]   a,
  input  logic signed [FRAC_BITS+3:0]   b,
  input  logic signed [FRAC_BITS+3:0]   c,
  output logic signed [FRAC_BITS+5:0]   res,
  output ata_pkg::lane_st_t             st
);

  localparam int GW = FRAC_BITS + 4;
  localparam int MW = FRAC_BITS + 3;
  localparam int SQW = 2 * MW;
  localparam int SW = SQW + 1;
  localparam int RW = (SW + 2 * ata_pkg::PRE_SHIFT + 1) / 2;
  localparam int VW = 2 * RW;
  localparam int XW = RW + 3;
  localparam int CNTW = $clog2(RW + 1);
  localparam int AW = ata_pkg::ANG_W;
  localparam int PW = AW + 3;
  localparam int RESW = FRAC_BITS + 6;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_MUL   = 7'b0000010,
    PH_LOAD  = 7'b0000100,
    PH_SQRT  = 7'b0001000,
    PH_CINIT = 7'b0010000,
    PH_CORD  = 7'b0100000,
    PH_FIN   = 7'b1000000
  } phase_t;

  phase_t                ph_r, ph_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic                  neg_r, zero_r;
  logic [MW-1:0]         mag_r, ub_r, uc_r;
  logic [SQW-1:0]        sqb_r, sqc_r;
  logic [VW-1:0]         v_r, v_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic signed [XW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [AW-1:0]  ang_r, ang_nxt;
  logic signed [RESW-1:0] res_r, res_nxt;
  logic [GW-1:0]         a_abs, b_abs, c_abs;
  logic [VW-1:0]         trial;
  logic signed [XW-1:0]  xs, ys;
  logic signed [AW-1:0]  step_ang;
  logic [AW-2:0]         ang_c;
  logic [PW-1:0]         prod;
  logic [PW+FRAC_BITS-1:0] scl;
  logic [RESW-1:0]       mag_res;

  // Operand magnitudes.
  always_comb begin
    a_abs = a[GW-1] ? (~a + 1'b1) : a;
    b_abs = b[GW-1] ? (~b + 1'b1) : b;
    c_abs = c[GW-1] ? (~c + 1'b1) : c;
  end

  // Datapath of the root, the CORDIC and the final scaling.
  always_comb begin
    trial = root_r + bit_r;
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    step_ang = ata_pkg::atan_val(cnt_r[4:0]);
    ang_c = ang_r[AW-1] ? '0 : ang_r[AW-2:0];
    prod = PW'(ang_c) * PW'(10);
    scl = {prod, {FRAC_BITS{1'b0}}} + ((PW + FRAC_BITS)'(1) << (ata_pkg::ANG_BITS - 1));
    mag_res = scl[PW+FRAC_BITS-1:ata_pkg::ANG_BITS];
  end

  // Phase sequencing and register updates.
  always_comb begin
    ph_nxt = ph_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    v_nxt = v_r;
    root_nxt = root_r;
    bit_nxt = bit_r;
    x_nxt = x_r;
    y_nxt = y_r;
    ang_nxt = ang_r;
    res_nxt = res_r;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          ph_nxt = PH_MUL;
        end
      end
      PH_MUL: begin
        ph_nxt = PH_LOAD;
      end
      PH_LOAD: begin
        v_nxt = VW'(SW'(sqb_r) + SW'(sqc_r)) << (2 * ata_pkg::PRE_SHIFT);
        root_nxt = '0;
        bit_nxt = VW'(1) << (VW - 2);
        cnt_nxt = '0;
        ph_nxt = PH_SQRT;
      end
      PH_SQRT: begin
        if (v_r >= trial) begin
          v_nxt = v_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(RW - 1)) begin
          ph_nxt = PH_CINIT;
        end
      end
      PH_CINIT: begin
        x_nxt = $signed(XW'(root_r[RW-1:0]));
        y_nxt = $signed(XW'(mag_r) << ata_pkg::PRE_SHIFT);
        ang_nxt = '0;
        cnt_nxt = '0;
        ph_nxt = PH_CORD;
      end
      PH_CORD: begin
        if (!y_r[XW-1]) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          ang_nxt = ang_r + step_ang;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          ang_nxt = ang_r - step_ang;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(ata_pkg::CORDIC_STEPS - 1)) begin
          ph_nxt = PH_FIN;
        end
      end
      PH_FIN: begin
        if (zero_r) begin
          res_nxt = '0;
        end else if (neg_r) begin
          res_nxt = -$signed(mag_res);
        end else begin
          res_nxt = $signed(mag_res);
        end
        done_nxt = 1'b1;
        ph_nxt = PH_IDLE;
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
    end
    if (start && ph_r == PH_IDLE) begin
      neg_r <= a[GW-1];
      zero_r <= (a == '0);
      mag_r <= a_abs[MW-1:0];
      ub_r <= b_abs[MW-1:0];
      uc_r <= c_abs[MW-1:0];
    end
    if (ph_r == PH_MUL) begin
      sqb_r <= ub_r * ub_r;
      sqc_r <= uc_r * uc_r;
    end
    v_r <= v_nxt;
    root_r <= root_nxt;
    bit_r <= bit_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    ang_r <= ang_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;
  assign st.busy = (ph_r != PH_IDLE);
  assign st.done = done_r;

endmodule

[rtl/ata_merge.sv]
// Merging stage: output register, stored roll and roll change.
module ata_merge #(
  parameter int FRAC_BITS = ata_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    load,
  input  logic signed [FRAC_BITS+3:0]             gx,
  input  logic signed [FRAC_BITS+3:0]             gy,
  input  logic signed [FRAC_BITS+3:0]             gz,
  input  logic signed [FRAC_BITS+5:0]             pitch,
  input  logic signed [FRAC_BITS+5:0]             roll,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic signed [ata_pkg::G_OUT_W-1:0]      out_gx,
  output logic signed [ata_pkg::G_OUT_W-1:0]      out_gy,
  output logic signed [ata_pkg::G_OUT_W-1:0]      out_gz,
  output logic signed [ata_pkg::ANG_OUT_W-1:0]    out_pitch,
  output logic signed [ata_pkg::ANG_OUT_W-1:0]    out_roll,
  output logic signed [ata_pkg::DELTA_OUT_W-1:0]  out_roll_delta
);

  localparam int RESW = FRAC_BITS + 6;

  logic                    valid_r, valid_nxt;
  logic signed [RESW-1:0]  last_roll_r;
  logic signed [RESW:0]    delta;

  // Change of roll against the previous item.
  assign delta = $signed({roll[RESW-1], roll}) - $signed({last_roll_r[RESW-1], last_roll_r});

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_roll_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (load) begin
        last_roll_r <= roll;
      end
    end
    if (load) begin
      out_gx <= ata_pkg::G_OUT_W'(gx);
      out_gy <= ata_pkg::G_OUT_W'(gy);
      out_gz <= ata_pkg::G_OUT_W'(gz);
      out_pitch <= ata_pkg::ANG_OUT_W'(pitch);
      out_roll <= ata_pkg::ANG_OUT_W'(roll);
      out_roll_delta <= ata_pkg::DELTA_OUT_W'(delta);
    end
  end

  assign out_valid = valid_r;

endmodule

[rtl/accel_tilt_angle_top.sv]
// Top level of the accelerometer tilt angle block.
// Each item runs through the g conversion of the axis lanes, then the square root of
// RW = FRAC_BITS + 20 root bits and the CORDIC of the angle lanes, then the merge stage.
// The bit-per-cycle square root and the 20-step CORDIC set the pace; one item is in work at a time.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) idles the sequencer, drops out_valid and clears stored roll.
module accel_tilt_angle_top #(
  parameter int ADC_BITS = ata_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = ata_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [ata_pkg::RAW_W-1:0]               in_raw_x,
  input  logic [ata_pkg::RAW_W-1:0]               in_raw_y,
  input  logic [ata_pkg::RAW_W-1:0]               in_raw_z,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [ata_pkg::G_OUT_W-1:0]      out_gx,
  output logic signed [ata_pkg::G_OUT_W-1:0]      out_gy,
  output logic signed [ata_pkg::G_OUT_W-1:0]      out_gz,
  output logic signed [ata_pkg::ANG_OUT_W-1:0]    out_pitch,
  output logic signed [ata_pkg::ANG_OUT_W-1:0]    out_roll,
  output logic signed [ata_pkg::DELTA_OUT_W-1:0]  out_roll_delta
);

  localparam int GW = FRAC_BITS + 4;
  localparam int RESW = FRAC_BITS + 6;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_ANGLE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic accept, tilt_start, load;
  logic lanes_busy;
  logic signed [GW-1:0] gx, gy, gz;
  logic signed [RESW-1:0] pitch, roll;
  ata_pkg::lane_st_t st_x, st_y, st_z, st_p, st_r;

  assign in_ready = (state_r == ST_IDLE) && !lanes_busy;
  assign accept = in_valid && in_ready;
  assign tilt_start = (state_r == ST_CONV) && st_x.done;
  assign load = (state_r == ST_DONE) && (!out_valid || out_ready);

  // Sequencer over the axis lanes, the angle lanes and the merge stage.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CONV;
      ST_CONV: if (st_x.done) state_nxt = ST_ANGLE;
      ST_ANGLE: if (st_p.done) state_nxt = ST_DONE;
      ST_DONE: if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Axis lanes.
  ata_gconv #(.ADC_BITS(ADC_BITS), .FRAC_BITS(FRAC_BITS)) u_gx (
    .clk(clk), .rst_n(rst_n), .start(accept), .code(in_raw_x), .g(gx), .st(st_x));
  ata_gconv #(.ADC_BITS(ADC_BITS), .FRAC_BITS(FRAC_BITS)) u_gy (
    .clk(clk), .rst_n(rst_n), .start(accept), .code(in_raw_y), .g(gy), .st(st_y));
  ata_gconv #(.ADC_BITS(ADC_BITS), .FRAC_BITS(FRAC_BITS)) u_gz (
    .clk(clk), .rst_n(rst_n), .start(accept), .code(in_raw_z), .g(gz), .st(st_z));

  // Angle lanes: pitch and roll.
  ata_tilt #(.FRAC_BITS(FRAC_BITS)) u_pitch (
    .clk(clk), .rst_n(rst_n), .start(tilt_start), .a(gx), .b(gy), .c(gz),
    .res(pitch), .st(st_p));
  ata_tilt #(.FRAC_BITS(FRAC_BITS)) u_roll (
    .clk(clk), .rst_n(rst_n), .start(tilt_start), .a(gy), .b(gx), .c(gz),
    .res(roll), .st(st_r));

  // Merge stage.
  ata_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .rst_n(rst_n), .load(load),
    .gx(gx), .gy(gy), .gz(gz), .pitch(pitch), .roll(roll),
    .out_ready(out_ready), .out_valid(out_valid),
    .out_gx(out_gx), .out_gy(out_gy), .out_gz(out_gz),
    .out_pitch(out_pitch), .out_roll(out_roll), .out_roll_delta(out_roll_delta));

  // The lanes run in lock step; a new item also waits until every lane is idle.
  assign lanes_busy = st_x.busy | st_y.busy | st_z.busy | st_p.busy | st_r.busy
                    | st_y.done | st_z.done | st_r.done;

endmodule

[rtl/ata_check.sv]
// Port-level checker for the tilt angle block, bound to the top level.
module ata_check (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [ata_pkg::G_OUT_W-1:0]      out_gx,
  input logic signed [ata_pkg::ANG_OUT_W-1:0]    out_pitch,
  input logic signed [ata_pkg::ANG_OUT_W-1:0]    out_roll,
  input logic signed [ata_pkg::DELTA_OUT_W-1:0]  out_roll_delta
);

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && out_valid && !out_ready) |=> (out_valid && $stable(out_gx)
      && $stable(out_pitch) && $stable(out_roll) && $stable(out_roll_delta)))
    else $error("result changed while stalled");

  // An item in work blocks the next one.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while busy");

  // Reset leaves the block empty and ready.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

endmodule

bind accel_tilt_angle_top ata_check u_ata_check (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_gx(out_gx),
  .out_pitch(out_pitch), .out_roll(out_roll), .out_roll_delta(out_roll_delta));

[bench/tb_top.sv]
// Self-checking testbench for the accelerometer tilt angle block.
`timescale 1ns / 100ps

module tb_top;

  localparam int LIMIT_CYCLES = 600000;
  localparam int N_RANDOM = 1130;
  localparam int RAWW = ata_pkg::RAW_W;
  localparam int FS = (1 << ata_pkg::ADC_BITS_DEF) - 1;

  // One expected result item.
  typedef struct {
    logic signed [ata_pkg::G_OUT_W-1:0] gx;
    logic signed [ata_pkg::G_OUT_W-1:0] gy;
    logic signed [ata_pkg::G_OUT_W-1:0] gz;
    logic signed [ata_pkg::ANG_OUT_W-1:0] pitch;
    logic signed [ata_pkg::ANG_OUT_W-1:0] roll;
    logic signed [ata_pkg::DELTA_OUT_W-1:0] roll_delta;
  } tilt_res_t;

  // Directed sample with an optional typed-in result.
  typedef struct {
    logic [RAWW-1:0] x;
    logic [RAWW-1:0] y;
    logic [RAWW-1:0] z;
    bit known;
    tilt_res_t res;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RAWW-1:0] in_raw_x = '0;
  logic [RAWW-1:0] in_raw_y = '0;
  logic [RAWW-1:0] in_raw_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ata_pkg::G_OUT_W-1:0] out_gx, out_gy, out_gz;
  logic signed [ata_pkg::ANG_OUT_W-1:0] out_pitch, out_roll;
  logic signed [ata_pkg::DELTA_OUT_W-1:0] out_roll_delta;

  tilt_res_t pending_q[$];
  longint prev_roll;
  int n_errors = 0;
  int cycle_cnt = 0;
  bit rx_quiet = 1'b0;
  sample_row_t dir_tab[$];

  always #1 clk = ~clk;

  accel_tilt_angle_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_raw_x(in_raw_x), .in_raw_y(in_raw_y), .in_raw_z(in_raw_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_gx(out_gx), .out_gy(out_gy), .out_gz(out_gz),
    .out_pitch(out_pitch), .out_roll(out_roll), .out_roll_delta(out_roll_delta)
  );

  // Code to g in Q12, quotient rounded to nearest.
  function automatic longint code_to_g(input longint code);
    longint num;
    num = (code * 10) << ata_pkg::FRAC_BITS_DEF;
    return (num + FS / 2) / FS - (longint'(5) << ata_pkg::FRAC_BITS_DEF);
  endfunction

  // Integer square root by the bit-pair method.
  function automatic longint int_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Ten times atan2(a, sqrt(b^2+c^2)) by vectoring CORDIC.
  function automatic longint tilt_angle(input longint a, input longint b, input longint c);
    longint ma, x, y, ang, xs, ys, res;
    if (a == 0) return 0;
    ma = a < 0 ? -a : a;
    x = int_root(longint'(b * b + c * c) << (2 * ata_pkg::PRE_SHIFT));
    y = ma << ata_pkg::PRE_SHIFT;
    ang = 0;
    for (int i = 0; i < ata_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang += longint'(ata_pkg::atan_val(i[4:0]));
      end else begin
        x = x - ys;
        y = y + xs;
        ang -= longint'(ata_pkg::atan_val(i[4:0]));
      end
    end
    if (ang < 0) ang = 0;
    res = ((ang * 10) << ata_pkg::FRAC_BITS_DEF) + (longint'(1) << (ata_pkg::ANG_BITS - 1));
    res = res >> ata_pkg::ANG_BITS;
    return a < 0 ? -res : res;
  endfunction

  // Predicts one sample and advances the stored roll.
  function automatic tilt_res_t predict_tilt(input logic [RAWW-1:0] rx,
                                             input logic [RAWW-1:0] ry,
                                             input logic [RAWW-1:0] rz);
    tilt_res_t r;
    longint gx, gy, gz, p, rl, d;
    gx = code_to_g(longint'(rx));
    gy = code_to_g(longint'(ry));
    gz = code_to_g(longint'(rz));
    p = tilt_angle(gx, gy, gz);
    rl = tilt_angle(gy, gx, gz);
    d = rl - prev_roll;
    r.gx = gx[ata_pkg::G_OUT_W-1:0];
    r.gy = gy[ata_pkg::G_OUT_W-1:0];
    r.gz = gz[ata_pkg::G_OUT_W-1:0];
    r.pitch = p[ata_pkg::ANG_OUT_W-1:0];
    r.roll = rl[ata_pkg::ANG_OUT_W-1:0];
    r.roll_delta = d[ata_pkg::DELTA_OUT_W-1:0];
    prev_roll = rl;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  // Sends one sample and waits for it to be taken.
  task automatic send_sample(input logic [RAWW-1:0] rx, input logic [RAWW-1:0] ry,
                             input logic [RAWW-1:0] rz);
    in_valid <= 1'b1;
    in_raw_x <= rx;
    in_raw_y <= ry;
    in_raw_z <= rz;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random sender gap unless in the final quiet stretch.
  task automatic sender_gap(input bit quiet);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 19);
      repeat (n) @(posedge clk);
    end
  endtask

  // Result checker; out_ready is driven by the receiver stall process below.
  always @(posedge clk) begin
    tilt_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        e = pending_q.pop_front();
        if (out_gx !== e.gx) report_mismatch("gx", longint'(out_gx), longint'(e.gx));
        if (out_gy !== e.gy) report_mismatch("gy", longint'(out_gy), longint'(e.gy));
        if (out_gz !== e.gz) report_mismatch("gz", longint'(out_gz), longint'(e.gz));
        if (out_pitch !== e.pitch)
          report_mismatch("pitch", longint'(out_pitch), longint'(e.pitch));
        if (out_roll !== e.roll)
          report_mismatch("roll", longint'(out_roll), longint'(e.roll));
        if (out_roll_delta !== e.roll_delta)
          report_mismatch("roll_delta", longint'(out_roll_delta), longint'(e.roll_delta));
      end
    end
  end

  // Receiver stalls come in bursts.
  initial begin
    int n;
    forever begin
      if (!rx_quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 19);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 30);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic sample_row_t mk_row(input int x, input int y, input int z);
    sample_row_t r;
    r.x = x[RAWW-1:0];
    r.y = y[RAWW-1:0];
    r.z = z[RAWW-1:0];
    r.known = 1'b0;
    return r;
  endfunction

  // Stimulus.
  initial begin
    sample_row_t row;
    tilt_res_t e;
    logic [RAWW-1:0] rx, ry, rz;
    int mode;
    prev_roll = 0;

    // All axes at full negative scale: g is exactly -5 on each.
    row = mk_row(0, 0, 0);
    row.known = 1'b1;
    row.res.gx = -16'sd20480;
    row.res.gy = -16'sd20480;
    row.res.gz = -16'sd20480;
    dir_tab.push_back(row);
    // Exact zero g is not reachable with a full scale of 1023; 511 and 512 sit nearest.
    row = mk_row(511, 512, 511);
    dir_tab.push_back(row);
    // Full positive scale on every axis: g is exactly +5.
    row = mk_row(1023, 1023, 1023);
    row.known = 1'b1;
    row.res.gx = 16'sd20480;
    row.res.gy = 16'sd20480;
    row.res.gz = 16'sd20480;
    dir_tab.push_back(row);
    dir_tab.push_back(mk_row(1023, 0, 0));
    dir_tab.push_back(mk_row(0, 1023, 0));
    dir_tab.push_back(mk_row(0, 0, 1023));
    dir_tab.push_back(mk_row(1023, 511, 511));
    dir_tab.push_back(mk_row(0, 512, 512));
    dir_tab.push_back(mk_row(511, 1023, 512));
    dir_tab.push_back(mk_row(512, 0, 511));
    dir_tab.push_back(mk_row(512, 512, 0));
    dir_tab.push_back(mk_row(511, 511, 1023));
    dir_tab.push_back(mk_row(10'h2aa, 10'h155, 10'h3ff));
    dir_tab.push_back(mk_row(10'h155, 10'h2aa, 10'h000));
    dir_tab.push_back(mk_row(1, 1022, 700));
    dir_tab.push_back(mk_row(1022, 1, 300));
    // Minimum then maximum roll, the largest roll step.
    dir_tab.push_back(mk_row(511, 0, 511));
    dir_tab.push_back(mk_row(511, 1023, 511));
    dir_tab.push_back(mk_row(511, 0, 511));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; the full-scale rows have their g fields typed in.
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      e = predict_tilt(row.x, row.y, row.z);
      if (row.known) begin
        e.gx = row.res.gx;
        e.gy = row.res.gy;
        e.gz = row.res.gz;
      end
      pending_q.push_back(e);
      send_sample(row.x, row.y, row.z);
      sender_gap(1'b0);
    end
    in_valid <= 1'b0;

    // Hold off until every result is back.
    while (pending_q.size() != 0) @(posedge clk);

    // Random samples; the last stretch runs without idling.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 60) rx_quiet = 1'b1;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        rx = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
        ry = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
        rz = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
      end else if (mode == 1) begin
        rx = RAWW'($urandom_range(508, 515));
        ry = RAWW'($urandom_range(508, 515));
        rz = RAWW'($urandom_range(508, 515));
      end else begin
        rx = RAWW'($urandom_range(0, 1023));
        ry = RAWW'($urandom_range(0, 1023));
        rz = RAWW'($urandom_range(0, 1023));
      end
      pending_q.push_back(predict_tilt(rx, ry, rz));
      send_sample(rx, ry, rz);
      sender_gap(rx_quiet);
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
